### hdl/dpcp_pkg.sv
// ----------------------------------------------------------------------------
// dpcp_pkg
// Shared types and constants for the copy/insert delta command parser.
// ----------------------------------------------------------------------------
package dpcp_pkg;

  // width of offsets, lengths and the old-file length
  localparam int unsigned LenBits = 24;
  // accumulators carry one extra bit so that saturation always fails the range check
  localparam int unsigned AccW    = LenBits + 1;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // stream characters
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    KindLit  = 2'd0,
    KindCopy = 2'd1,
    KindEnd  = 2'd2,
    KindErr  = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PhIdle     = 7'b0000001,
    PhDelim    = 7'b0000010,
    PhLit      = 7'b0000100,
    PhOffFirst = 7'b0001000,
    PhOff      = 7'b0010000,
    PhLenFirst = 7'b0100000,
    PhLen      = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    kind_e              result_kind;
    logic [7:0]         literal_byte;
    logic [LenBits-1:0] copy_offset;
    logic [LenBits-1:0] copy_length;
    logic               last_result;
  } out_item_t;

  // results of one parse step: count (0..2) and the two slots
  typedef struct packed {
    logic [1:0]           n;
    out_item_t [1:0]      item;
  } res_t;

endpackage

### hdl/dpcp_parser.sv
// ----------------------------------------------------------------------------
// dpcp_parser
// Parse state and one-step decode of a registered stream byte into results.
// ----------------------------------------------------------------------------
module dpcp_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  dpcp_pkg::in_item_t            item_i,
  input  logic [dpcp_pkg::LenBits-1:0]  old_length_i,
  output dpcp_pkg::res_t                res_o
);

  dpcp_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                    delim_q, delim_d;
  logic [dpcp_pkg::AccW-1:0]     off_q, off_d;
  logic [dpcp_pkg::AccW-1:0]     len_q, len_d;

  logic [7:0] b;
  logic       eos;
  logic       is_digit;
  logic       is_plus;
  logic       is_hash;
  logic       is_crlf;
  logic       copy_ok;
  logic [dpcp_pkg::AccW:0] span;
  dpcp_pkg::res_t res;

  // decimal accumulate with saturation at all ones
  function automatic logic [dpcp_pkg::AccW-1:0] acc_digit(
    input logic [dpcp_pkg::AccW-1:0] a,
    input logic [7:0]                c
  );
    logic [dpcp_pkg::AccW+3:0] p;
    logic [3:0]                dg;
    dg = 4'(c - dpcp_pkg::CharZero);
    p  = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{dpcp_pkg::AccW{1'b0}}, dg};
    if (|p[dpcp_pkg::AccW+3:dpcp_pkg::AccW]) begin
      return {dpcp_pkg::AccW{1'b1}};
    end
    return p[dpcp_pkg::AccW-1:0];
  endfunction

  // byte classification
  assign b        = item_i.byte_in;
  assign eos      = item_i.stream_end;
  assign is_digit = !eos && (b >= dpcp_pkg::CharZero) && (b <= dpcp_pkg::CharNine);
  assign is_plus  = (b == dpcp_pkg::CharPlus);
  assign is_hash  = (b == dpcp_pkg::CharHash);
  assign is_crlf  = (b == dpcp_pkg::CharCr) || (b == dpcp_pkg::CharLf);

  // range check of the pending copy against the old file
  assign span    = {1'b0, off_q} + {1'b0, len_q};
  assign copy_ok = (off_q < {1'b0, old_length_i}) && (span <= {2'b0, old_length_i});

  // next state and results of one step
  always_comb begin
    phase_d = phase_q;
    delim_d = delim_q;
    off_d   = off_q;
    len_d   = len_q;
    res     = '0;
    case (phase_q)
      dpcp_pkg::PhIdle: begin
        if (eos) begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindEnd;
        end else if (is_plus) begin
          phase_d = dpcp_pkg::PhDelim;
        end else if (is_hash) begin
          off_d   = '0;
          len_d   = '0;
          phase_d = dpcp_pkg::PhOffFirst;
        end else if (!is_crlf) begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindErr;
        end
      end
      dpcp_pkg::PhDelim: begin
        if (eos) begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindErr;
          phase_d = dpcp_pkg::PhIdle;
        end else begin
          delim_d = b;
          phase_d = dpcp_pkg::PhLit;
        end
      end
      dpcp_pkg::PhLit: begin
        if (eos) begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindErr;
          phase_d = dpcp_pkg::PhIdle;
        end else if (b == delim_q) begin
          phase_d = dpcp_pkg::PhIdle;
        end else begin
          res.n = 2'd1;
          res.item[0].result_kind  = dpcp_pkg::KindLit;
          res.item[0].literal_byte = b;
        end
      end
      dpcp_pkg::PhOffFirst, dpcp_pkg::PhOff: begin
        if (is_digit) begin
          off_d   = acc_digit(off_q, b);
          phase_d = dpcp_pkg::PhOff;
        end else if (!eos && b == dpcp_pkg::CharComma && phase_q == dpcp_pkg::PhOff) begin
          phase_d = dpcp_pkg::PhLenFirst;
        end else begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindErr;
          phase_d = dpcp_pkg::PhIdle;
        end
      end
      dpcp_pkg::PhLenFirst: begin
        if (is_digit) begin
          len_d   = acc_digit(len_q, b);
          phase_d = dpcp_pkg::PhLen;
        end else begin
          res.n = 2'd1;
          res.item[0].result_kind = dpcp_pkg::KindErr;
          phase_d = dpcp_pkg::PhIdle;
        end
      end
      dpcp_pkg::PhLen: begin
        if (is_digit) begin
          len_d = acc_digit(len_q, b);
        end else begin
          phase_d = dpcp_pkg::PhIdle;
          res.n   = 2'd1;
          if (!copy_ok) begin
            res.item[0].result_kind = dpcp_pkg::KindErr;
          end else begin
            res.item[0].result_kind = dpcp_pkg::KindCopy;
            res.item[0].copy_offset = off_q[dpcp_pkg::LenBits-1:0];
            res.item[0].copy_length = len_q[dpcp_pkg::LenBits-1:0];
            // closing byte is parsed as the next command
            if (eos) begin
              res.n = 2'd2;
              res.item[1].result_kind = dpcp_pkg::KindEnd;
            end else if (is_plus) begin
              phase_d = dpcp_pkg::PhDelim;
            end else if (is_hash) begin
              off_d   = '0;
              len_d   = '0;
              phase_d = dpcp_pkg::PhOffFirst;
            end else if (!is_crlf) begin
              res.n = 2'd2;
              res.item[1].result_kind = dpcp_pkg::KindErr;
            end
          end
        end
      end
      default: begin
        phase_d = dpcp_pkg::PhIdle;
        res.n   = 2'd1;
        res.item[0].result_kind = dpcp_pkg::KindErr;
      end
    endcase
    // mark the final result of this step
    if (res.n == 2'd1) begin
      res.item[0].last_result = 1'b1;
    end else if (res.n == 2'd2) begin
      res.item[1].last_result = 1'b1;
    end
  end

  assign res_o = res;

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpcp_pkg::PhIdle;
      delim_q <= '0;
      off_q   <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      delim_q <= delim_d;
      off_q   <= off_d;
      len_q   <= len_d;
    end
  end

`ifndef SYNTHESIS
  // a copy descriptor only comes out when a length was being parsed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.n != 2'd0 && res_o.item[0].result_kind == dpcp_pkg::KindCopy
    |-> phase_q == dpcp_pkg::PhLen)
    else $error("copy result outside of length phase");

  // two results per step only follow a valid copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.n == 2'd2 |-> res_o.item[0].result_kind == dpcp_pkg::KindCopy)
    else $error("double result without copy");
`endif

endmodule

### hdl/dpcp_res_fifo.sv
// ----------------------------------------------------------------------------
// dpcp_res_fifo
// Small result queue: takes up to two results per cycle, delivers one.
// ----------------------------------------------------------------------------
module dpcp_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dpcp_pkg::res_t       res_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dpcp_pkg::out_item_t  out_data_o
);

  dpcp_pkg::out_item_t           mem [dpcp_pkg::FifoDepth];
  logic [dpcp_pkg::PtrW-1:0]     wptr_q, wptr_d;
  logic [dpcp_pkg::PtrW-1:0]     rptr_q, rptr_d;
  logic [dpcp_pkg::CntW-1:0]     count_q, count_d;
  logic [1:0]                    push_n;
  logic                          pop;

  assign push_n      = push_i ? res_i.n : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem[rptr_q];
  // room for a full two-result step
  assign space_o     = (count_q <= dpcp_pkg::CntW'(dpcp_pkg::FifoDepth - 2));

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d  = wptr_q + dpcp_pkg::PtrW'(push_n);
    rptr_d  = rptr_q + dpcp_pkg::PtrW'(pop);
    count_d = count_q + dpcp_pkg::CntW'(push_n) - dpcp_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem[wptr_q] <= res_i.item[0];
    end
    if (push_n == 2'd2) begin
      mem[wptr_q + dpcp_pkg::PtrW'(1)] <= res_i.item[1];
    end
  end

`ifndef SYNTHESIS
  // fill never goes past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dpcp_pkg::CntW'(dpcp_pkg::FifoDepth))
    else $error("result queue overflow");

  // a push only happens with room for both slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> space_o)
    else $error("push into full result queue");
`endif

endmodule

### hdl/delta_patch_command_parser.sv
// ----------------------------------------------------------------------------
// delta_patch_command_parser
// Copy/insert delta stream parser: bytes in, literals and copy descriptors out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one stream byte per
//     transaction, or a stream_end marker.
//   out channel (out_valid_o/out_ready_i/out_data_o): literal, copy, end or
//     error results; last_result marks the final result of one input byte.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes old_length,
//     always ready; write it only while no transaction is in flight.
// Path: the input byte is registered, parsed combinationally and written
//   into a four-entry result queue, whose fill count drives out_valid_o.
// Throughput: one byte per cycle while the queue has room for two results;
//   a byte giving two results (copy closed by the stream end or an unknown
//   byte) leaves an extra result to drain when the receiver only takes one
//   result per cycle.
// Reset: parser returns to idle, queue empties, old_length clears to zero.
// Stall: when the receiver holds out_ready_i low the queue fills and
//   in_ready_o drops once fewer than two free entries remain.
// ----------------------------------------------------------------------------
module delta_patch_command_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dpcp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dpcp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpcp_pkg::LenBits-1:0]  cfg_data_i
);

  logic                          in_valid_q;
  dpcp_pkg::in_item_t            in_item_q;
  logic [dpcp_pkg::LenBits-1:0]  old_length_q;
  logic                          space;
  logic                          fire;
  dpcp_pkg::res_t                res;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && space;
  assign in_ready_o  = !in_valid_q || fire;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      old_length_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  // parse step
  dpcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_item_q),
    .old_length_i (old_length_q),
    .res_o        (res)
  );

  // result queue
  dpcp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte stream test of the copy/insert delta command parser: a directed set of
// corner cases, then random command streams under several old-file lengths,
// each result checked field by field against an in-bench parser model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpcp_pkg::*;

  // run limits and pacing
  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseBytes   = 250;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned HoldAfter    = 600;
  localparam int unsigned HoldCycles   = 400;

  // what one entry of the stimulus queue asks the driver to do
  typedef enum logic [1:0] {
    OpByte,
    OpCfg,
    OpDrain
  } stim_op_e;

  typedef struct packed {
    stim_op_e           op;
    in_item_t           item;
    logic [LenBits-1:0] len;
  } stim_t;

  // dut signals
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LenBits-1:0] cfg_data_i  = '0;

  // stimulus and parse results waiting for the dut
  stim_t       stream_q[$];
  out_item_t   parsed_q[$];
  int unsigned stream_bytes = 0;

  // parser model state
  phase_e             parse_ph  = PhIdle;
  logic [7:0]         cur_delim = '0;
  logic [AccW-1:0]    off_acc   = '0;
  logic [AccW-1:0]    len_acc   = '0;
  logic [LenBits-1:0] old_len   = '0;

  // bookkeeping
  int unsigned mismatches  = 0;
  int unsigned bytes_taken = 0;
  int unsigned quiet       = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned send_gap    = 0;
  int unsigned send_run    = 0;
  int unsigned recv_gap    = 0;
  int unsigned recv_run    = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  delta_patch_command_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // idle length: mostly none or short, a few long, with gap-free runs now and then
  function automatic int unsigned pick_gap(inout int unsigned run_left);
    int unsigned r;
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      run_left = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic void emit(kind_e k, logic [7:0] lit, logic [LenBits-1:0] off,
                               logic [LenBits-1:0] len);
    out_item_t r;
    r.result_kind  = k;
    r.literal_byte = lit;
    r.copy_offset  = off;
    r.copy_length  = len;
    r.last_result  = 1'b0;
    parsed_q.insert(parsed_q.size(), r);
  endfunction

  // decimal digit into an accumulator, pinned at all ones
  function automatic logic [AccW-1:0] acc_digit(logic [AccW-1:0] acc, logic [7:0] b);
    logic [63:0] v;
    v = 64'(acc) * 64'd10 + 64'(b - CharZero);
    if (v > 64'({AccW{1'b1}})) return {AccW{1'b1}};
    return v[AccW-1:0];
  endfunction

  // byte seen while idle; false on an unknown command
  function automatic logic take_command(logic [7:0] b);
    if (b == CharPlus) begin
      parse_ph = PhDelim;
      return 1'b1;
    end
    if (b == CharHash) begin
      off_acc  = '0;
      len_acc  = '0;
      parse_ph = PhOffFirst;
      return 1'b1;
    end
    parse_ph = PhIdle;
    return (b == CharCr) || (b == CharLf);
  endfunction

  // one accepted input transaction: append the results it must produce
  function automatic void parse_byte(in_item_t it);
    logic [7:0]  b;
    logic        fin;
    logic        dig;
    int unsigned n0;
    out_item_t   tail;
    b   = it.byte_in;
    fin = it.stream_end;
    dig = (b >= CharZero) && (b <= CharNine);
    n0  = parsed_q.size();
    case (parse_ph)
      PhIdle: begin
        if (fin) emit(KindEnd, '0, '0, '0);
        else if (!take_command(b)) emit(KindErr, '0, '0, '0);
      end
      PhDelim: begin
        if (fin) begin
          emit(KindErr, '0, '0, '0);
          parse_ph = PhIdle;
        end else begin
          cur_delim = b;
          parse_ph  = PhLit;
        end
      end
      PhLit: begin
        if (fin) begin
          emit(KindErr, '0, '0, '0);
          parse_ph = PhIdle;
        end else if (b == cur_delim) begin
          parse_ph = PhIdle;
        end else begin
          emit(KindLit, b, '0, '0);
        end
      end
      PhOffFirst, PhOff: begin
        if (!fin && dig) begin
          off_acc  = acc_digit(off_acc, b);
          parse_ph = PhOff;
        end else if (!fin && b == CharComma && parse_ph == PhOff) begin
          parse_ph = PhLenFirst;
        end else begin
          emit(KindErr, '0, '0, '0);
          parse_ph = PhIdle;
        end
      end
      PhLenFirst: begin
        if (!fin && dig) begin
          len_acc  = acc_digit(len_acc, b);
          parse_ph = PhLen;
        end else begin
          emit(KindErr, '0, '0, '0);
          parse_ph = PhIdle;
        end
      end
      PhLen: begin
        if (!fin && dig) begin
          len_acc = acc_digit(len_acc, b);
        end else begin
          parse_ph = PhIdle;
          // copy must lie inside the old file
          if (off_acc >= old_len || 27'(off_acc) + 27'(len_acc) > 27'(old_len)) begin
            emit(KindErr, '0, '0, '0);
          end else begin
            emit(KindCopy, '0, off_acc[LenBits-1:0], len_acc[LenBits-1:0]);
            if (fin) emit(KindEnd, '0, '0, '0);
            else if (!take_command(b)) emit(KindErr, '0, '0, '0);
          end
        end
      end
      default: begin
        parse_ph = PhIdle;
        emit(KindErr, '0, '0, '0);
      end
    endcase
    // flag the final result of this byte
    if (parsed_q.size() > n0) begin
      tail = parsed_q.pop_back();
      tail.last_result = 1'b1;
      parsed_q.insert(parsed_q.size(), tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_entry(input stim_op_e op, input logic [7:0] b, input logic fin,
                           input logic [LenBits-1:0] len);
    stim_t e;
    e.op              = op;
    e.item.byte_in    = b;
    e.item.stream_end = fin;
    e.len             = len;
    stream_q.insert(stream_q.size(), e);
    if (op == OpByte) stream_bytes++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_entry(OpByte, b, 1'b0, '0);
  endtask

  // stream end marker, the ignored byte field random
  task automatic add_end();
    add_entry(OpByte, 8'($urandom_range(0, 255)), 1'b1, '0);
  endtask

  task automatic add_cfg(input logic [LenBits-1:0] len);
    add_entry(OpCfg, '0, 1'b0, len);
  endtask

  // breaks a command: stream end or any byte
  task automatic add_break();
    if ($urandom_range(0, 1) != 0) add_end();
    else add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_digits(input longint unsigned v, input int unsigned lead);
    string s;
    s = $sformatf("%0d", v);
    repeat (lead) add_byte(CharZero);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // copy command: mostly in range, some at the edges, some far out or saturating
  task automatic gen_copy(input logic [LenBits-1:0] lim);
    longint unsigned off;
    longint unsigned len;
    int unsigned     r;
    int unsigned     cut;
    r = $urandom_range(0, 99);
    if (lim != 0 && r < 70) begin
      if ($urandom_range(0, 1) != 0) off = $urandom_range(0, lim - 1);
      else off = lim - 1 - $urandom_range(0, (lim > 4) ? 3 : lim - 1);
      len = $urandom_range(0, 32'(lim - off));
      if ($urandom_range(0, 9) == 0) len = lim - off + 1;
    end else if (r < 85) begin
      off = lim + $urandom_range(0, 2);
      len = $urandom_range(0, 20);
    end else begin
      off = (r < 93) ? longint'($urandom()) : {$urandom(), $urandom()};
      len = (r < 93) ? longint'($urandom()) : {$urandom(), $urandom()};
    end
    cut = $urandom_range(0, 29);
    add_byte(CharHash);
    if (cut == 0) begin
      add_break();
      return;
    end
    add_digits(off, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
    if (cut == 1) begin
      add_break();
      return;
    end
    add_byte(CharComma);
    if (cut == 2) begin
      add_break();
      return;
    end
    add_digits(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  // literal run, mostly closed by its delimiter
  task automatic gen_literal();
    logic [7:0]  d;
    logic [7:0]  b;
    int unsigned n;
    int unsigned r;
    add_byte(CharPlus);
    r = $urandom_range(0, 99);
    if (r < 2) begin
      add_end();
      return;
    end
    d = 8'($urandom_range(0, 255));
    add_byte(d);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == d) b = ~d;
      add_byte(b);
    end
    if (r < 92) add_byte(d);
    else if (r < 96) add_end();
  endtask

  // ---------------------------------------------------------------------------
  // driver: input and config transactions from the stimulus queue
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic  nxt_in;
    logic  nxt_cfg;
    stim_t head;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      nxt_in  = in_valid_i && !in_ready_o;
      nxt_cfg = cfg_valid_i && !cfg_ready_o;
      // retire the finished transaction
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o)) begin
        stream_q.delete(0);
        send_gap = pick_gap(send_run);
      end
      // offer the next entry once the gap has run out
      if (!nxt_in && !nxt_cfg && stream_q.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else begin
          head = stream_q[0];
          case (head.op)
            OpByte: begin
              nxt_in = 1'b1;
              in_data_i <= head.item;
            end
            OpCfg: begin
              if (quiet >= SettleCycles) begin
                nxt_cfg = 1'b1;
                cfg_data_i <= head.len;
              end
            end
            OpDrain: begin
              if (quiet >= SettleCycles) stream_q.delete(0);
            end
            default: stream_q.delete(0);
          endcase
        end
      end
      in_valid_i  <= nxt_in;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off once traffic is flowing
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) recv_gap = pick_gap(recv_run);
      if (!hold_done && bytes_taken >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: track config, predict on input, check on output
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    out_item_t want;
    logic      got_in;
    logic      got_out;
    if (rst_ni) begin
      got_in  = in_valid_i && in_ready_o;
      got_out = out_valid_o && out_ready_i;
      if (cfg_valid_i && cfg_ready_o) old_len = cfg_data_i;
      if (got_in) begin
        parse_byte(in_data_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (got_out) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected result transaction: kind %0d", out_data_o.result_kind);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data_o.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_data_o.result_kind);
            mismatches++;
          end
          if (out_data_o.literal_byte !== want.literal_byte) begin
            $error("literal_byte: expected %0h, got %0h", want.literal_byte,
                   out_data_o.literal_byte);
            mismatches++;
          end
          if (out_data_o.copy_offset !== want.copy_offset) begin
            $error("copy_offset: expected %0d, got %0d", want.copy_offset,
                   out_data_o.copy_offset);
            mismatches++;
          end
          if (out_data_o.copy_length !== want.copy_length) begin
            $error("copy_length: expected %0d, got %0d", want.copy_length,
                   out_data_o.copy_length);
            mismatches++;
          end
          if (out_data_o.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result,
                   out_data_o.last_result);
            mismatches++;
          end
        end
      end
      // cycles with nothing in flight, used before config writes and at the end
      if (got_in || got_out || parsed_q.size() != 0 || in_valid_i || cfg_valid_i)
        quiet <= 0;
      else
        quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_proc
    logic [LenBits-1:0] lim;
    logic [LenBits-1:0] phase_len[NumPhases];
    int unsigned        r;

    // idle end, unknown command, line breaks, end right after '+'
    add_end();
    add_byte("x");
    add_byte(CharCr);
    add_byte(CharLf);
    add_byte(CharPlus);
    add_end();
    // copy against an empty old file, closed by the end
    add_byte(CharHash);
    add_byte("7");
    add_byte(CharComma);
    add_byte("0");
    add_end();
    // largest old file: literal zero with delimiter all ones
    add_cfg(24'hFFFFFF);
    add_byte(CharPlus);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    // copy closed by a new copy, which then sees a comma too early
    add_byte(CharHash);
    add_byte("0");
    add_byte(CharComma);
    add_byte("5");
    add_byte(CharHash);
    add_byte(CharComma);
    // copy closed by the stream end
    add_byte(CharHash);
    add_byte("1");
    add_byte(CharComma);
    add_byte("2");
    add_end();

    // random streams over several old-file lengths
    phase_len[0] = 24'hFFFFFF;
    phase_len[1] = '0;
    phase_len[2] = 24'($urandom_range(1, 40));
    phase_len[3] = 24'($urandom());
    phase_len[4] = 24'd1;
    phase_len[5] = 24'($urandom_range(1000, 100000));
    phase_len[6] = 24'hFFFFFF;
    phase_len[7] = 24'($urandom_range(1, 40));
    for (int p = 0; p < NumPhases; p++) begin
      lim = phase_len[p];
      add_cfg(lim);
      while (stream_bytes < (p + 1) * PhaseBytes) begin
        r = $urandom_range(0, 99);
        if (r < 40) gen_copy(lim);
        else if (r < 72) gen_literal();
        else if (r < 80) add_byte(($urandom_range(0, 1) != 0) ? CharCr : CharLf);
        else if (r < 88) add_end();
        else if (r < 99) add_byte(8'($urandom_range(0, 255)));
        else add_entry(OpDrain, '0, 1'b0, '0);
      end
    end
    add_end();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cycle_cnt < CycleLimit &&
           !(stream_q.size() == 0 && !in_valid_i && !cfg_valid_i &&
             parsed_q.size() == 0 && quiet >= SettleCycles))
      @(posedge clk_i);

    if (cycle_cnt >= CycleLimit) $display("testbench: done, errors");
    else if (mismatches == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

### filelist.f
hdl/dpcp_pkg.sv
hdl/dpcp_parser.sv
hdl/dpcp_res_fifo.sv
hdl/delta_patch_command_parser.sv
verif/testbench.sv
